@@ rtl/core/plms_pkg.sv @@
// shared types, constants and the crc helper of the protected load message scheduler
package plms_pkg;

  localparam int TICK_BITS = 20;
  localparam int CFG_TICK_W = 20;
  localparam int CMP_W = (TICK_BITS > CFG_TICK_W) ? TICK_BITS : CFG_TICK_W;
  localparam int REP_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [7:0] DATA_ID_RST = 8'h16;
  localparam logic [CFG_TICK_W-1:0] LOAD_ON_RST = CFG_TICK_W'(100);
  localparam logic [CFG_TICK_W-1:0] CYCLE_LEN_RST = CFG_TICK_W'(1020000);
  localparam logic [REP_W-1:0] REPEAT_RST = REP_W'(100);
  localparam logic [3:0] ALIVE_WRAP_RST = 4'd14;
  localparam logic [7:0] POLY_RST = 8'h07;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_ID      = 3'd0,
    REG_LOAD_ON_TICK = 3'd1,
    REG_CYCLE_LENGTH = 3'd2,
    REG_REPEAT       = 3'd3,
    REG_ALIVE_WRAP   = 3'd4,
    REG_CRC_POLY     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]            data_id;
    logic [CFG_TICK_W-1:0] load_on_tick;
    logic [CFG_TICK_W-1:0] cycle_length;
    logic [REP_W-1:0]      repeat_interval;
    logic [3:0]            alive_wrap;
    logic [7:0]            crc_polynomial;
  } cfg_t;

  // one frame to send
  typedef struct packed {
    logic load;
    logic last;
  } cmd_t;

  // frames produced by one tick, first goes out first
  typedef struct packed {
    logic [1:0] count;
    cmd_t       first;
    cmd_t       second;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] crc;
    logic [3:0] alive;
    logic       load;
    logic       last;
  } stage_t;

  // eight msb-first shift steps of a byte already xored into the register
  function automatic logic [7:0] crc8_shift(input logic [7:0] value, input logic [7:0] poly);
    logic [7:0] c;
    c = value;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/plms_front.sv @@
// tick scheduler: keeps tick, repeat and load state and classifies each tick into frames
module plms_front import plms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  tick_valid,
  input  logic  tick_enable,
  input  logic  room,
  output logic  tick_ready,
  output push_t push
);

  logic [TICK_BITS-1:0] tick_count, tick_count_next, tick_base;
  logic [REP_W-1:0]     repeat_count, repeat_count_next, repeat_inc, interval;
  logic                 load_level, load_level_next;
  logic                 accept, ev, per, lv;

  assign tick_ready = room;
  assign accept = tick_valid && room;

  always_comb begin
    ev = 1'b1;
    lv = load_level;
    tick_base = tick_count;
    if (CMP_W'(tick_count) == CMP_W'(cfg.cycle_length)) begin
      tick_base = '0;
      lv = 1'b0;
    end else if (CMP_W'(tick_count) == CMP_W'(cfg.load_on_tick)) begin
      lv = 1'b1;
    end else if (tick_count == '0) begin
      lv = 1'b0;
    end else begin
      ev = 1'b0;
    end
    per = (repeat_count == '0);

    interval = (cfg.repeat_interval == '0) ? REP_W'(1) : cfg.repeat_interval;
    repeat_inc = repeat_count + REP_W'(1);

    tick_count_next = tick_count;
    repeat_count_next = repeat_count;
    load_level_next = load_level;
    push = '0;
    if (accept) begin
      if (!tick_enable) begin
        tick_count_next = '0;
        repeat_count_next = '0;
        load_level_next = 1'b0;
      end else begin
        tick_count_next = tick_base + TICK_BITS'(1);
        repeat_count_next = (repeat_inc >= interval) ? '0 : repeat_inc;
        load_level_next = lv;
        if (ev && per) begin
          push.count = 2'd2;
          push.first = '{load: lv, last: 1'b0};
          push.second = '{load: lv, last: 1'b1};
        end else if (ev || per) begin
          push.count = 2'd1;
          push.first = '{load: lv, last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      repeat_count <= '0;
      load_level <= 1'b0;
    end else begin
      tick_count <= tick_count_next;
      repeat_count <= repeat_count_next;
      load_level <= load_level_next;
    end
  end

endmodule

@@ rtl/core/plms_queue.sv @@
// short frame queue between scheduler and frame builder, two writes and one read a cycle
module plms_queue import plms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output logic  room,
  output logic  not_empty,
  output cmd_t  head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign room = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end
  end

endmodule

@@ rtl/core/plms_back.sv @@
// frame builder: alive counter and a crc pipeline of one byte per stage
module plms_back import plms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        not_empty,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output stage_t      out_frame
);

  stage_t     s1, s2, s3, res;
  logic [3:0] alive_value;
  logic       advance;

  assign advance = !res.valid || out_ready;
  assign pop = advance && not_empty;
  assign out_valid = res.valid;
  assign out_frame = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_value <= '0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      res.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= pop;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
      res.valid <= s3.valid;
      if (pop) begin
        alive_value <= (alive_value >= cfg.alive_wrap) ? 4'd0 : alive_value + 4'd1;
      end

      // payload, one crc byte per stage
      s1.crc <= crc8_shift({4'd0, alive_value}, cfg.crc_polynomial);
      s1.alive <= alive_value;
      s1.load <= head.load;
      s1.last <= head.last;

      s2.crc <= crc8_shift(s1.crc ^ cfg.data_id, cfg.crc_polynomial);
      s2.alive <= s1.alive;
      s2.load <= s1.load;
      s2.last <= s1.last;

      s3.crc <= crc8_shift(s2.crc ^ {7'd0, s2.load}, cfg.crc_polynomial);
      s3.alive <= s2.alive;
      s3.load <= s2.load;
      s3.last <= s2.last;

      res.crc <= crc8_shift(s3.crc ^ PAD_BYTE, cfg.crc_polynomial);
      res.alive <= s3.alive;
      res.load <= s3.load;
      res.last <= s3.last;
    end
  end

endmodule

@@ rtl/core/protected_load_message_scheduler.sv @@
// Protected load message scheduler. Each input item is one time tick (enable in bit 0).
// An accepted tick yields zero, one or two frames, each carrying a CRC-8 over alive
// count, data id, load and a zero byte; the last frame of a tick has tlast set. The
// scheduler takes one tick per cycle while its four-entry frame queue has room for two
// frames; the frame builder sends one frame per cycle while m_tready does not stall it,
// through a four-stage CRC pipeline (one byte per stage), so ticks that each send two
// frames are held back to the rate at which the builder drains them. Configuration
// writes are always accepted and take effect on the next cycle.
module protected_load_message_scheduler import plms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] enable, [7:1] zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [7:0] crc_byte, [11:8] alive_count,
                                           // [19:12] data_id_out, [20] load_request
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  push_t  push;
  cmd_t   head;
  stage_t frame;
  logic   room, not_empty, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_id <= DATA_ID_RST;
      cfg.load_on_tick <= LOAD_ON_RST;
      cfg.cycle_length <= CYCLE_LEN_RST;
      cfg.repeat_interval <= REPEAT_RST;
      cfg.alive_wrap <= ALIVE_WRAP_RST;
      cfg.crc_polynomial <= POLY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DATA_ID:      cfg.data_id <= cfg_data[7:0];
        REG_LOAD_ON_TICK: cfg.load_on_tick <= cfg_data[CFG_TICK_W-1:0];
        REG_CYCLE_LENGTH: cfg.cycle_length <= cfg_data[CFG_TICK_W-1:0];
        REG_REPEAT:       cfg.repeat_interval <= cfg_data[REP_W-1:0];
        REG_ALIVE_WRAP:   cfg.alive_wrap <= cfg_data[3:0];
        REG_CRC_POLY:     cfg.crc_polynomial <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  plms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick_valid  (s_tvalid),
    .tick_enable (s_tdata[0]),
    .room        (room),
    .tick_ready  (s_tready),
    .push        (push)
  );

  plms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  plms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_frame (frame)
  );

  assign m_tdata = {3'd0, frame.load, cfg.data_id, frame.alive, frame.crc};
  assign m_tlast = frame.last;

endmodule
